// File: sv/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: sv/hmb_pkg.sv
package hmb_pkg;

    // fixed field widths
    localparam int KEY_W        = 31;
    localparam int VALUE_W      = 64;
    localparam int STATUS_W     = 3;
    localparam int BUCKET_OUT_W = 5;

    typedef logic [KEY_W-1:0]        t_key;
    typedef logic [VALUE_W-1:0]      t_value;
    typedef logic [STATUS_W-1:0]     t_status;
    typedef logic [BUCKET_OUT_W-1:0] t_bucket_out;

    // operation codes
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // result status codes
    localparam t_status ST_NEW       = 3'd0;
    localparam t_status ST_UPDATED   = 3'd1;
    localparam t_status ST_REMOVED   = 3'd2;
    localparam t_status ST_NOT_FOUND = 3'd3;
    localparam t_status ST_FULL      = 3'd4;

    // one operation in flight
    typedef struct packed {
        logic   kind;
        t_key   key;
        t_value value;
    } t_op;

endpackage

// File: sv/hash_table_modulo_buckets.sv
// Key/value table with BUCKETS buckets of WAYS ways each. An operation is
// issued by raising start while busy is low; busy never rises, so one
// operation can be issued every clock cycle. i_kind selects insert/update
// (the value of a key already present is overwritten, otherwise the lowest
// free way of the bucket is taken, and a full bucket drops the insert with
// status "bucket full") or remove (frees the way holding the key, or reports
// "not found"). The bucket is i_key modulo BUCKETS, reported on o_bucket in
// its low 5 bits. Each operation gives exactly one result: o_valid is high
// for one cycle with o_status, o_bucket and o_table_empty (no entries left
// after this operation). Results come in issue order and cannot be held
// off; take them when o_valid is high. An operation passes through the
// modulo unit (reciprocal multiply, then a multiply-back and subtract, each
// behind a register) followed by the registered read of the bucket's key
// row; the lookup and compare on that row are combinational and its
// write-back happens in the same cycle, so back-to-back operations on the
// same bucket see each other's updates. No clearing pass is needed after
// reset: per-way valid bits are cleared at once, and key and value storage
// is only consulted for valid ways.

`include "assert_macros.svh"

module hash_table_modulo_buckets #(
    parameter int BUCKETS = 20,
    parameter int WAYS    = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic                 i_kind,
    input  hmb_pkg::t_key        i_key,
    input  hmb_pkg::t_value      i_value,
    output logic                 busy,
    output logic                 o_valid,
    output hmb_pkg::t_status     o_status,
    output hmb_pkg::t_bucket_out o_bucket,
    output logic                 o_table_empty
);

    // index and counter widths
    localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CAP = BUCKETS * WAYS;
    localparam int CW  = $clog2(CAP + 1);

    // reciprocal for key / BUCKETS: q = (key * MULT) >> SHIFT is exact for
    // every 31-bit key with SHIFT = 31 + ceil(log2(BUCKETS))
    localparam int SHIFT = hmb_pkg::KEY_W + $clog2(BUCKETS);
    localparam int PW    = SHIFT + hmb_pkg::KEY_W;
    localparam int MW    = hmb_pkg::KEY_W + 2;
    localparam logic [63:0]   MULT_W = ((64'd1 << SHIFT) / BUCKETS) + 64'd1;
    localparam logic [MW-1:0] MULT   = MULT_W[MW-1:0];

    typedef logic [BW-1:0]                     t_bidx;
    typedef logic [WW-1:0]                     t_way;
    typedef logic [CW-1:0]                     t_count;
    typedef logic [PW-1:0]                     t_prod;
    typedef logic [WAYS-1:0]                   t_vrow;
    typedef logic [WAYS-1:0][hmb_pkg::KEY_W-1:0] t_krow;

    localparam hmb_pkg::t_key BUCKETS_K = hmb_pkg::t_key'(BUCKETS);
    localparam t_count        CAP_K     = t_count'(CAP);

    // pipeline registers
    logic           r_p1_vld, r_p2_vld, r_p3_vld, r_p4_vld;
    hmb_pkg::t_op   r_p1_op, r_p2_op, r_p3_op, r_p4_op;
    t_prod          r_p2_prod;
    hmb_pkg::t_key  r_p3_qb;
    t_bidx          r_p4_bucket;
    t_krow          r_rd_keys;

    // table storage
    t_krow          r_key_mem [BUCKETS];
    hmb_pkg::t_value r_val_mem [BUCKETS][WAYS];
    t_vrow          r_valid   [BUCKETS];
    t_count         r_count;

    // result registers
    logic                 r_res_vld;
    hmb_pkg::t_status     r_res_status;
    hmb_pkg::t_bucket_out r_res_bucket;
    logic                 r_res_empty;

    // stage 3/4 bucket and stage 4 decision
    hmb_pkg::t_key    p3_diff;
    t_bidx            p3_bucket;
    t_vrow            row_vld;
    t_vrow            hit_vec;
    t_vrow            free_vec;
    t_way             hit_way;
    t_way             free_way;
    t_way             wr_way;
    t_krow            wr_row;
    t_vrow            n_row_vld;
    t_count           n_count;
    hmb_pkg::t_status n_status;
    logic             key_we;
    logic             val_we;
    logic             any_valid;

    wire accept = start && !busy;

    // the table never stalls the issuing side
    assign busy = 1'b0;

    // ---- pipeline control ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_p3_vld  <= 1'b0;
            r_p4_vld  <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_p1_vld  <= accept;
            r_p2_vld  <= r_p1_vld;
            r_p3_vld  <= r_p2_vld;
            r_p4_vld  <= r_p3_vld;
            r_res_vld <= r_p4_vld;
        end
    end

    // ---- pipeline payload ----
    always_ff @(posedge i_clk) begin
        r_p1_op.kind  <= i_kind;
        r_p1_op.key   <= i_key;
        r_p1_op.value <= i_value;
        // reciprocal multiply
        r_p2_op   <= r_p1_op;
        r_p2_prod <= t_prod'(r_p1_op.key) * t_prod'(MULT);
        // multiply the quotient back
        r_p3_op   <= r_p2_op;
        r_p3_qb   <= r_p2_prod[SHIFT +: hmb_pkg::KEY_W] * BUCKETS_K;
        // remainder selects the row being read
        r_p4_op     <= r_p3_op;
        r_p4_bucket <= p3_bucket;
    end

    // remainder is below BUCKETS, so only the low index bits matter
    assign p3_diff   = r_p3_op.key - r_p3_qb;
    assign p3_bucket = p3_diff[BW-1:0];

    // ---- key rows: one write port, one registered read port ----
    // a row written in the same cycle it is read is passed straight through
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key_mem[r_p4_bucket] <= wr_row;
        end
        if (key_we && (r_p4_bucket == p3_bucket)) begin
            r_rd_keys <= wr_row;
        end else begin
            r_rd_keys <= r_key_mem[p3_bucket];
        end
    end

    // ---- values: written only ----
    always_ff @(posedge i_clk) begin
        if (val_we) begin
            r_val_mem[r_p4_bucket][wr_way] <= r_p4_op.value;
        end
    end

    // ---- lookup and decision on the current row ----
    assign row_vld = r_valid[r_p4_bucket];

    always_comb begin
        hit_vec  = '0;
        free_vec = '0;
        hit_way  = '0;
        free_way = '0;
        for (int w = 0; w < WAYS; w++) begin
            hit_vec[w]  = row_vld[w] && (r_rd_keys[w] == r_p4_op.key);
            free_vec[w] = !row_vld[w];
        end
        // lowest set way wins
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_way = t_way'(w);
            end
            if (free_vec[w]) begin
                free_way = t_way'(w);
            end
        end
    end

    always_comb begin
        n_status  = hmb_pkg::ST_NOT_FOUND;
        key_we    = 1'b0;
        val_we    = 1'b0;
        wr_way    = hit_way;
        wr_row    = r_rd_keys;
        n_row_vld = row_vld;
        n_count   = r_count;
        case (r_p4_op.kind)
            hmb_pkg::KIND_INSERT: begin
                if (|hit_vec) begin
                    n_status = hmb_pkg::ST_UPDATED;
                    val_we   = r_p4_vld;
                end else if (|free_vec) begin
                    n_status            = hmb_pkg::ST_NEW;
                    wr_way              = free_way;
                    wr_row[free_way]    = r_p4_op.key;
                    n_row_vld[free_way] = 1'b1;
                    n_count             = r_count + t_count'(1);
                    key_we              = r_p4_vld;
                    val_we              = r_p4_vld;
                end else begin
                    n_status = hmb_pkg::ST_FULL;
                end
            end
            hmb_pkg::KIND_REMOVE: begin
                if (|hit_vec) begin
                    n_status           = hmb_pkg::ST_REMOVED;
                    n_row_vld[hit_way] = 1'b0;
                    n_count            = r_count - t_count'(1);
                end
            end
            default: begin
                n_status = hmb_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    // ---- valid bits and entry count ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < BUCKETS; b++) begin
                r_valid[b] <= '0;
            end
            r_count <= '0;
        end else if (r_p4_vld) begin
            r_valid[r_p4_bucket] <= n_row_vld;
            r_count              <= n_count;
        end
    end

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        r_res_status <= n_status;
        r_res_bucket <= hmb_pkg::t_bucket_out'(r_p4_bucket);
        r_res_empty  <= (n_count == '0);
    end

    assign o_valid       = r_res_vld;
    assign o_status      = r_res_status;
    assign o_bucket      = r_res_bucket;
    assign o_table_empty = r_res_empty;

    // ---- checks ----
    always_comb begin
        any_valid = 1'b0;
        for (int b = 0; b < BUCKETS; b++) begin
            any_valid = any_valid | (|r_valid[b]);
        end
    end

    `ASSERT_IMPLIES(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CAP_K)
    `ASSERT_IMPLIES(a_count_matches_valid, i_clk, i_rst_n, 1'b1, (r_count == '0) == !any_valid)
    `ASSERT_IMPLIES(a_result_latency, i_clk, i_rst_n, o_valid, $past(accept, 5))
    `ASSERT_IMPLIES(a_new_counts_up, i_clk, i_rst_n, o_valid && (o_status == hmb_pkg::ST_NEW), r_count == $past(r_count) + t_count'(1))

endmodule
